// ===== hdl/smpc_pkg.sv =====
// ----------------------------------------------------------------------------
// smpc_pkg - shared types and constants of the scanned matrix pulse counter
// Request codes, group and line geometry, counter memory geometry and the
// sequencer state type.
// ----------------------------------------------------------------------------
package smpc_pkg;

  // request kinds carried in the input tuser field
  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_READ   = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_EN_LOW    = 2'd0;
  localparam logic [1:0] CFG_EN_HIGH   = 2'd1;
  localparam logic [1:0] CFG_EN_DIRECT = 2'd2;

  // geometry: eight driven groups plus the direct group, sixteen lines each
  localparam int          LINE_STRIDE   = 16;
  localparam int          GROUP_SLOTS   = 9;
  localparam logic [3:0]  DIRECT_GROUP  = 4'd8;
  localparam int          COUNTER_SLOTS = GROUP_SLOTS * LINE_STRIDE;
  localparam int          CNT_ADDR_W    = $clog2(COUNTER_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } seq_state_t;

endpackage

// ===== hdl/smpc_ram.sv =====
// ----------------------------------------------------------------------------
// smpc_ram - generic single write, single read synchronous RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ----------------------------------------------------------------------------
module smpc_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 144
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/smpc_cfg.sv =====
// ----------------------------------------------------------------------------
// smpc_cfg - counter enable registers
// Holds the three enable registers and selects the sixteen enables of one
// group.
// ----------------------------------------------------------------------------
module smpc_cfg
  import smpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic [3:0]  sel_group,
  output logic [15:0] group_en
);

  logic [63:0] en_low_r;
  logic [63:0] en_high_r;
  logic [15:0] en_direct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_low_r    <= '0;
      en_high_r   <= '0;
      en_direct_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_EN_LOW:    en_low_r    <= cfg_wdata;
        CFG_EN_HIGH:   en_high_r   <= cfg_wdata;
        CFG_EN_DIRECT: en_direct_r <= cfg_wdata[15:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (sel_group)
      4'd0:         group_en = en_low_r[15:0];
      4'd1:         group_en = en_low_r[31:16];
      4'd2:         group_en = en_low_r[47:32];
      4'd3:         group_en = en_low_r[63:48];
      4'd4:         group_en = en_high_r[15:0];
      4'd5:         group_en = en_high_r[31:16];
      4'd6:         group_en = en_high_r[47:32];
      4'd7:         group_en = en_high_r[63:48];
      DIRECT_GROUP: group_en = en_direct_r;
      default:      group_en = '0;
    endcase
  end

endmodule

// ===== hdl/scanned_matrix_pulse_counter_core.sv =====
// ----------------------------------------------------------------------------
// scanned_matrix_pulse_counter_core - rising edge pulse counter for a
// scanned input matrix
// Flow: a sample word passes ST_SWEEP, ST_DRAIN and ST_FINISH, a read word
//   ST_READ and ST_FINISH, a clear/other word ST_FINISH alone; the result
//   word is loaded into the output register from ST_FINISH once it is free.
// Throughput: one word at a time; a sample sweeps the counter RAM one line
//   per cycle through its single read and write port.
// Reset: synchronous, active low; clears enables, previous masks, counter
//   valid bits (all counters read as zero) and the handshake state.
// ----------------------------------------------------------------------------
module scanned_matrix_pulse_counter_core
  import smpc_pkg::*;
#(
  parameter int OUTPUT_GROUPS = 8,
  parameter int INPUT_LINES   = 16,
  parameter int COUNT_WIDTH   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // group[3:0], input_mask[19:4], input_port[23:20]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // count[31:0], edge_found[32], zero fill[39:33]
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  localparam logic [3:0]  GROUP_LIM = 4'(OUTPUT_GROUPS);
  localparam logic [4:0]  LINE_LIM  = 5'(INPUT_LINES);
  localparam logic [3:0]  LAST_LINE = 4'(INPUT_LINES - 1);
  localparam logic [15:0] LINE_MASK = 16'((32'd1 << INPUT_LINES) - 32'd1);

  // --------------------------------------------------------------------------
  // Input word unpacking
  // --------------------------------------------------------------------------
  logic        in_acc;
  logic [3:0]  in_group;
  logic [15:0] in_mask;
  logic [3:0]  in_port;
  req_t        in_req;
  logic        in_grp_ok;

  assign in_acc    = in_tvalid & in_tready;
  assign in_group  = in_tdata[3:0];
  assign in_mask   = in_tdata[19:4] & LINE_MASK;
  assign in_port   = in_tdata[23:20];
  assign in_req    = req_t'(in_tuser);
  // direct group is always present; driven groups only below OUTPUT_GROUPS
  assign in_grp_ok = (in_group == DIRECT_GROUP) || (in_group < GROUP_LIM);

  // --------------------------------------------------------------------------
  // Enable registers
  // --------------------------------------------------------------------------
  logic [15:0] grp_en;

  smpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sel_group (in_group),
    .group_en  (grp_en)
  );

  // --------------------------------------------------------------------------
  // Previous masks, one per group; small enough to live in flops
  // --------------------------------------------------------------------------
  logic [15:0] prev_mask_r [GROUP_SLOTS];
  logic [15:0] prev_sel;
  logic [15:0] rising;

  assign prev_sel = in_grp_ok ? prev_mask_r[in_group] : '0;
  assign rising   = in_mask & ~prev_sel;

  // --------------------------------------------------------------------------
  // Sequencer registers
  // --------------------------------------------------------------------------
  seq_state_t        state_r, state_nxt;
  logic [3:0]        line_r, line_nxt;
  logic [3:0]        grp_r;
  logic [15:0]       hits_r;
  logic              en_bit_r;
  logic              res_edge_r;
  logic [31:0]       res_count_r;

  // write stage of the sweep, in the cycle after the counter read
  logic              wr_pend_r;
  logic [3:0]        wr_line_r;

  // counter valid bits; a clear drops them all at once
  logic [COUNTER_SLOTS-1:0] cnt_valid_r;

  // output register
  logic              out_valid_r;
  logic [31:0]       out_count_r;
  logic              out_edge_r;
  logic              out_free;

  assign out_free = ~out_valid_r | out_tready;

  // --------------------------------------------------------------------------
  // Counter memory
  // --------------------------------------------------------------------------
  logic                   ram_rd_en;
  logic [CNT_ADDR_W-1:0]  ram_rd_addr;
  logic [COUNT_WIDTH-1:0] ram_rd_data;
  logic                   ram_wr_en;
  logic [CNT_ADDR_W-1:0]  ram_wr_addr;
  logic [COUNT_WIDTH-1:0] ram_wr_data;
  logic [63:0]            rd_ext;

  smpc_ram #(
    .DATA_W (COUNT_WIDTH),
    .DEPTH  (COUNTER_SLOTS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign rd_ext = 64'(ram_rd_data);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    case (state_r)
      ST_IDLE: begin
        // a read keeps its port in line_r for the valid bit lookup;
        // a sample starts its sweep at line zero
        line_nxt = (in_acc && in_req == REQ_READ) ? in_port : '0;
        if (in_acc) begin
          if (in_req == REQ_SAMPLE && in_grp_ok) begin
            state_nxt = ST_SWEEP;
          end else if (in_req == REQ_READ && in_grp_ok && ({1'b0, in_port} < LINE_LIM)) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SWEEP: begin
        line_nxt = line_r + 4'd1;
        if (line_r == LAST_LINE) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_READ:   state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: RAM ports and handshake
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready   = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = {grp_r, line_r};
    case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        // issue the read of a count request straight from the input word
        ram_rd_en   = in_acc && (in_req == REQ_READ) && in_grp_ok;
        ram_rd_addr = {in_group, in_port};
      end
      ST_SWEEP: begin
        // only lines with an enabled rising edge touch the memory
        ram_rd_en = hits_r[line_r];
      end
      default: ;
    endcase
  end

  // write back counter + 1; an entry dropped by a clear restarts from zero and is written as one
  always_comb begin
    ram_wr_en   = wr_pend_r;
    ram_wr_addr = {grp_r, wr_line_r};
    ram_wr_data = cnt_valid_r[ram_wr_addr] ? ram_rd_data + COUNT_WIDTH'(1)
                                           : COUNT_WIDTH'(1);
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= '0;
      wr_pend_r   <= 1'b0;
      cnt_valid_r <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < GROUP_SLOTS; g++) begin
        prev_mask_r[g] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      line_r    <= line_nxt;
      wr_pend_r <= (state_r == ST_SWEEP) && ram_rd_en;

      if (ram_wr_en) begin
        cnt_valid_r[ram_wr_addr] <= 1'b1;
      end

      if (in_acc) begin
        if (in_req == REQ_CLEAR) begin
          cnt_valid_r <= '0;
        end
        if (in_req == REQ_SAMPLE && in_grp_ok) begin
          prev_mask_r[in_group] <= in_mask;
        end
      end

      // load a new result word, or drop the one just taken
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    wr_line_r <= line_r;
    if (in_acc) begin
      grp_r       <= in_group;
      hits_r      <= (in_req == REQ_SAMPLE && in_grp_ok) ? (rising & grp_en) : '0;
      en_bit_r    <= grp_en[in_port];
      res_edge_r  <= (in_req == REQ_SAMPLE && in_grp_ok) ? (rising != '0) : 1'b0;
      res_count_r <= '0;
    end
    if (state_r == ST_READ) begin
      // disabled or cleared pair reads as zero
      res_count_r <= (en_bit_r && cnt_valid_r[{grp_r, line_r}]) ? rd_ext[31:0] : '0;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_count_r <= res_count_r;
      out_edge_r  <= res_edge_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_edge_r, out_count_r};

endmodule
